// File: rtl/core/lsc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the label stack clusterer
// Table sizes, field widths, register indexes, controller state and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package lsc_pkg;

   localparam int LABEL_CAPACITY = 32;
   localparam int IDX_W          = $clog2(LABEL_CAPACITY);
   localparam int CNT_W          = $clog2(LABEL_CAPACITY + 1);

   localparam int COORD_W    = 20;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQ_W       = 2 * DIFF_W - 1;
   localparam int DIST_W     = SQ_W + 1;
   localparam int RADIUS_W   = 24;
   localparam int SPACING_W  = 12;
   localparam int ROW_W      = 6;
   localparam int PROD_W     = SPACING_W + ROW_W;
   localparam int LY_W       = COORD_W + 1;
   localparam int CLUSTER_W  = 5;

   localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(63);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = RADIUS_W;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQUARED = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_SPACING    = CSR_IDX_W'(1);

   localparam logic [RADIUS_W-1:0]  RADIUS_RESET  = RADIUS_W'(65536);
   localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(272);

   // entry table word: {cluster, y, x}
   localparam int ENTRY_W   = IDX_W + 2 * COORD_W;
   // cluster table word: {next row, origin y, origin x}
   localparam int CLUSTER_WORD_W = ROW_W + 2 * COORD_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_PLACE
   } state_type;

   typedef struct packed {
      logic start;   // capture request, clear tables on frame start
      logic issue;   // read next entry into the distance pipeline
      logic lookup;  // pick cluster, read its row and origin
      logic pass;    // load unclustered result
      logic place;   // load placed result and update tables
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic cluster_full;
      logic out_free;
   } status_type;

endpackage

// File: rtl/core/lsc_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsc_ram: generic simple dual-port RAM
// One write port, one read port with enable; read data registered and held
// while the read enable is low.
// ---------------------------------------------------------------------------
module lsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lsc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsc_ctrl: label placement sequencer
// Accepts a request, runs the entry scan, chooses join/open/pass and hands
// the result to the output register when it is free.
// ---------------------------------------------------------------------------
module lsc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lsc_pkg::status_type status,
   output lsc_pkg::cmd_type    cmd
);

   import lsc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (!status.found && status.cluster_full) begin
               if (status.out_free) begin
                  cmd.pass = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.lookup = 1'b1;
               state_in   = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (status.out_free) begin
               cmd.place = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/lsc_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsc_datapath: tables, distance pipeline and result register
// Entry scan runs through a three-stage pipeline (difference, square,
// compare) fed one entry per cycle; the first match in order wins.
// ---------------------------------------------------------------------------
module lsc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  lsc_pkg::cmd_type                   cmd,
   output lsc_pkg::status_type                status,
   input  logic                               csr_write,
   input  logic [lsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lsc_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               req_frame_start,
   input  logic signed [lsc_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [lsc_pkg::COORD_W-1:0] req_point_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lsc_pkg::COORD_W-1:0] rsp_label_x,
   output logic signed [lsc_pkg::COORD_W-1:0] rsp_label_y,
   output logic [lsc_pkg::CLUSTER_W-1:0]      rsp_cluster_index,
   output logic [lsc_pkg::ROW_W-1:0]          rsp_row_index,
   output logic                               rsp_unclustered
);

   import lsc_pkg::*;

   // configuration
   logic [RADIUS_W-1:0]  radius_ff;
   logic [SPACING_W-1:0] spacing_ff;

   // item and table control
   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic [CNT_W-1:0] entry_count_ff, cluster_count_ff, scan_idx_ff;
   logic             found_ff;
   logic [IDX_W-1:0] found_cl_ff;
   logic             new_ff;
   logic [IDX_W-1:0] cl_ff;

   // distance pipeline
   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic [IDX_W-1:0]         cl2_ff, cl3_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;

   // result register
   logic                      out_valid_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff;
   logic [CLUSTER_W-1:0]      out_cl_ff;
   logic [ROW_W-1:0]          out_row_ff;
   logic                      out_unc_ff;

   // RAM ports
   logic                      issue_fire;
   logic                      entry_wr_en;
   logic [ENTRY_W-1:0]        entry_wr_data, entry_rd_data;
   logic [CLUSTER_WORD_W-1:0] clus_wr_data, clus_rd_data;
   logic [IDX_W-1:0]          cl_sel;

   // combinational datapath
   logic signed [COORD_W-1:0]  ent_x, ent_y;
   logic [IDX_W-1:0]           ent_cl;
   logic signed [DIFF_W-1:0]   dx_in, dy_in;
   logic signed [2*DIFF_W-1:0] prodx, prody;
   logic [DIST_W-1:0]          sum_sq;
   logic                       hit;
   logic signed [COORD_W-1:0]  ox, oy;
   logic [ROW_W-1:0]           row, row_next;
   logic [PROD_W-1:0]          offset;
   logic signed [LY_W-1:0]     ly;
   logic signed [COORD_W-1:0]  ly_sat;
   logic                       out_free;
   logic                       entry_room;

   assign issue_fire = cmd.issue && !found_ff && (scan_idx_ff < entry_count_ff);
   assign entry_room = entry_count_ff < CNT_W'(LABEL_CAPACITY);
   assign out_free   = !out_valid_ff || !rsp_stall;

   // ---------------- distance pipeline ----------------
   assign ent_x  = entry_rd_data[COORD_W-1:0];
   assign ent_y  = entry_rd_data[2*COORD_W-1:COORD_W];
   assign ent_cl = entry_rd_data[ENTRY_W-1:2*COORD_W];

   assign dx_in  = {px_ff[COORD_W-1], px_ff} - {ent_x[COORD_W-1], ent_x};
   assign dy_in  = {py_ff[COORD_W-1], py_ff} - {ent_y[COORD_W-1], ent_y};
   assign prodx  = dx_ff * dx_ff;
   assign prody  = dy_ff * dy_ff;
   assign sum_sq = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign hit    = v3_ff && !found_ff && (sum_sq <= DIST_W'(radius_ff));

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      cl2_ff <= ent_cl;
      sqx_ff <= prodx[SQ_W-1:0];
      sqy_ff <= prody[SQ_W-1:0];
      cl3_ff <= cl2_ff;
   end

   // ---------------- placement ----------------
   assign cl_sel = found_ff ? found_cl_ff : cluster_count_ff[IDX_W-1:0];

   assign ox  = new_ff ? px_ff : clus_rd_data[COORD_W-1:0];
   assign oy  = new_ff ? py_ff : clus_rd_data[2*COORD_W-1:COORD_W];
   assign row = new_ff ? '0 : clus_rd_data[CLUSTER_WORD_W-1:2*COORD_W];

   assign row_next = (row != ROW_MAX) ? row + ROW_W'(1) : row;
   assign offset   = PROD_W'(spacing_ff) * PROD_W'(row);
   assign ly       = {oy[COORD_W-1], oy} + $signed({{(LY_W-PROD_W){1'b0}}, offset});

   // sum of two 20-bit-range values fits 21 bits; clamp when top bits disagree
   always_comb begin
      if (ly[LY_W-1] != ly[LY_W-2]) begin
         ly_sat = ly[LY_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         ly_sat = ly[COORD_W-1:0];
      end
   end

   assign clus_wr_data  = {row_next, oy, ox};
   assign entry_wr_en   = cmd.place && entry_room;
   assign entry_wr_data = {cl_ff, py_ff, px_ff};

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff        <= RADIUS_RESET;
         spacing_ff       <= SPACING_RESET;
         entry_count_ff   <= '0;
         cluster_count_ff <= '0;
         scan_idx_ff      <= '0;
         found_ff         <= 1'b0;
         new_ff           <= 1'b0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_RADIUS_SQUARED: radius_ff  <= csr_data[RADIUS_W-1:0];
               CSR_ROW_SPACING:    spacing_ff <= csr_data[SPACING_W-1:0];
               default: ;
            endcase
         end

         if (cmd.start) begin
            scan_idx_ff <= '0;
            found_ff    <= 1'b0;
            v1_ff       <= 1'b0;
            v2_ff       <= 1'b0;
            v3_ff       <= 1'b0;
            if (req_frame_start) begin
               entry_count_ff   <= '0;
               cluster_count_ff <= '0;
            end
         end else begin
            v1_ff <= issue_fire;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            if (issue_fire) begin
               scan_idx_ff <= scan_idx_ff + CNT_W'(1);
            end
            if (hit) begin
               found_ff <= 1'b1;
            end
         end

         if (cmd.lookup) begin
            new_ff <= !found_ff;
         end

         if (cmd.place) begin
            if (new_ff) begin
               cluster_count_ff <= cluster_count_ff + CNT_W'(1);
            end
            if (entry_room) begin
               entry_count_ff <= entry_count_ff + CNT_W'(1);
            end
         end

         if (cmd.pass || cmd.place) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff <= req_point_x;
         py_ff <= req_point_y;
      end
      if (hit) begin
         found_cl_ff <= cl3_ff;
      end
      if (cmd.lookup) begin
         cl_ff <= cl_sel;
      end
      if (cmd.pass) begin
         out_x_ff   <= px_ff;
         out_y_ff   <= py_ff;
         out_cl_ff  <= '0;
         out_row_ff <= '0;
         out_unc_ff <= 1'b1;
      end else if (cmd.place) begin
         out_x_ff   <= ox;
         out_y_ff   <= ly_sat;
         out_cl_ff  <= CLUSTER_W'(cl_ff);
         out_row_ff <= row;
         out_unc_ff <= 1'b0;
      end
   end

   // ---------------- tables ----------------
   lsc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LABEL_CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_wr_en),
      .wr_addr (entry_count_ff[IDX_W-1:0]),
      .wr_data (entry_wr_data),
      .rd_en   (issue_fire),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (entry_rd_data)
   );

   lsc_ram #(
      .WIDTH (CLUSTER_WORD_W),
      .DEPTH (LABEL_CAPACITY)
   ) u_cluster_ram (
      .clock   (clock),
      .wr_en   (cmd.place),
      .wr_addr (cl_ff),
      .wr_data (clus_wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (cl_sel),
      .rd_data (clus_rd_data)
   );

   // ---------------- status and outputs ----------------
   assign status.scan_done    = found_ff ||
                                ((scan_idx_ff >= entry_count_ff) && !v1_ff && !v2_ff && !v3_ff);
   assign status.found        = found_ff;
   assign status.cluster_full = cluster_count_ff >= CNT_W'(LABEL_CAPACITY);
   assign status.out_free     = out_free;

   assign rsp_valid         = out_valid_ff;
   assign rsp_label_x       = out_x_ff;
   assign rsp_label_y       = out_y_ff;
   assign rsp_cluster_index = out_cl_ff;
   assign rsp_row_index     = out_row_ff;
   assign rsp_unclustered   = out_unc_ff;

endmodule

// File: rtl/core/label_stack_clusterer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// label_stack_clusterer: screen label placement by point clustering
// A request is taken only while idle; the entry scan runs until the first hit
// or the last entry, then the result is loaded once the output register is free.
// Throughput: one item at a time; the entry scan (one entry per cycle through
// a three-stage distance pipeline) sets the rate.
// Reset: synchronous; both tables empty, config registers at their default values.
// ---------------------------------------------------------------------------
module label_stack_clusterer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [lsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lsc_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_frame_start,
   input  logic signed [lsc_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [lsc_pkg::COORD_W-1:0] req_point_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lsc_pkg::COORD_W-1:0] rsp_label_x,
   output logic signed [lsc_pkg::COORD_W-1:0] rsp_label_y,
   output logic [lsc_pkg::CLUSTER_W-1:0]      rsp_cluster_index,
   output logic [lsc_pkg::ROW_W-1:0]          rsp_row_index,
   output logic                               rsp_unclustered
);

   import lsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   lsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lsc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_frame_start   (req_frame_start),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_label_x       (rsp_label_x),
      .rsp_label_y       (rsp_label_y),
      .rsp_cluster_index (rsp_cluster_index),
      .rsp_row_index     (rsp_row_index),
      .rsp_unclustered   (rsp_unclustered)
   );

endmodule
